[rtl/tile_distinct_color_limit_checker_assert.svh]
// Assertion macros shared by the tile color limit checker RTL.
`ifndef TILE_DISTINCT_COLOR_LIMIT_CHECKER_ASSERT_SVH
`define TILE_DISTINCT_COLOR_LIMIT_CHECKER_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define TDCLC_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define TDCLC_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/tdclc_pkg.sv]
// Package: shared constants and types of the tile color limit checker.
package tdclc_pkg;

  localparam int unsigned PALETTE_SIZE_DEF = 16;
  localparam int unsigned COLOR_W          = 32;
  localparam int unsigned OUT_CNT_W        = 5;
  localparam int unsigned COUNT_SAT        = 31;
  localparam logic [COLOR_W-1:0] TRANSP_RESET = 32'hFF00_FFFF;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } tdclc_state_e;

endpackage

[rtl/tile_distinct_color_limit_checker.sv]
// Top level: per-tile distinct color counter with overflow detection.
// Sequence: a counted word is accepted in ST_IDLE, compared against the stored colors in ST_SCAN
//   and committed in ST_DONE, which registers the result; a hit on a stored color ends the scan early.
// Flow: one word at a time; no new word is accepted until the last one is committed; ST_SCAN is
//   skipped when the word is not counted or the store is empty; a stalled output holds the commit.
// Reset (async, active low): count, failed flag, sequencer, output valid clear; key color magenta.
module tile_distinct_color_limit_checker #(
  parameter int unsigned PALETTE_SIZE = tdclc_pkg::PALETTE_SIZE_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // config: transparent color
  input  logic                          cfg_we_i,
  input  logic [tdclc_pkg::COLOR_W-1:0] cfg_wdata_i,
  // pixel input
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [tdclc_pkg::COLOR_W-1:0] s_axis_tdata,  // [31:0] pixel_color
  input  logic                          s_axis_tlast,  // last_in_tile
  // result output
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [7:0]                    m_axis_tdata,  // [0] overflow, [5:1] distinct_count,
                                                       // [6] tile_failed, [7] zero
  output logic                          m_axis_tlast   // tile_end
);

  `include "tile_distinct_color_limit_checker_assert.svh"

  localparam int unsigned STORE_DEPTH = PALETTE_SIZE - 1;
  localparam int unsigned IDX_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(PALETTE_SIZE + 1);

  // Registers
  tdclc_pkg::tdclc_state_e state_q, state_d;
  logic [tdclc_pkg::COLOR_W-1:0] transp_q;
  logic [CNT_W-1:0]              total_q, total_d;
  logic                          failed_q, failed_d;
  logic [CNT_W-1:0]              idx_q, idx_d;      // next store entry to read
  logic                          pend_q, pend_d;    // read in flight
  logic                          pend_last_q, pend_last_d;
  logic                          hit_q, hit_d;
  logic                          cand_q, cand_d;    // pixel is countable
  logic [tdclc_pkg::COLOR_W-1:0] pix_q, pix_d;
  logic                          last_q, last_d;
  logic                          out_valid_q, out_valid_d;
  logic                          out_ovf_q, out_ovf_d;
  logic [tdclc_pkg::OUT_CNT_W-1:0] out_cnt_q, out_cnt_d;
  logic                          out_failed_q, out_failed_d;
  logic                          out_last_q, out_last_d;

  // Store port
  logic                          rd_en;
  logic [IDX_W-1:0]              rd_addr;
  logic [tdclc_pkg::COLOR_W-1:0] rd_data;
  logic                          wr_en;

  // Commit terms
  logic             accept, slot_free, miss, ins, ovf, in_cand;
  logic [CNT_W-1:0] tot_new;
  logic             fail_new;

  tdclc_store #(
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (total_q[IDX_W-1:0]),
    .wr_data_i (pix_q),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  assign s_axis_tready = (state_q == tdclc_pkg::ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign slot_free     = !out_valid_q || m_axis_tready;

  // A pixel counts only when the tile is still live, alpha is nonzero and it is not the key color.
  assign in_cand = !failed_q && (s_axis_tdata[7:0] != 8'd0) && (s_axis_tdata != transp_q);

  // Commit decision for the pixel in hand
  assign miss     = cand_q && !hit_q;
  assign ins      = miss && (total_q < CNT_W'(STORE_DEPTH));
  assign ovf      = miss && !ins;
  assign tot_new  = ins ? (total_q + CNT_W'(1)) : (ovf ? CNT_W'(PALETTE_SIZE) : total_q);
  assign fail_new = failed_q || ovf;

  always_comb begin
    state_d      = state_q;
    total_d      = total_q;
    failed_d     = failed_q;
    idx_d        = idx_q;
    pend_d       = pend_q;
    pend_last_d  = pend_last_q;
    hit_d        = hit_q;
    cand_d       = cand_q;
    pix_d        = pix_q;
    last_d       = last_q;
    out_valid_d  = out_valid_q;
    out_ovf_d    = out_ovf_q;
    out_cnt_d    = out_cnt_q;
    out_failed_d = out_failed_q;
    out_last_d   = out_last_q;
    rd_en        = 1'b0;
    rd_addr      = idx_q[IDX_W-1:0];
    wr_en        = 1'b0;

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      tdclc_pkg::ST_IDLE: begin
        if (accept) begin
          pix_d       = s_axis_tdata;
          last_d      = s_axis_tlast;
          cand_d      = in_cand;
          hit_d       = 1'b0;
          idx_d       = '0;
          pend_d      = 1'b0;
          pend_last_d = 1'b0;
          // empty store: nothing to search
          state_d     = (in_cand && (total_q != '0)) ? tdclc_pkg::ST_SCAN : tdclc_pkg::ST_DONE;
        end
      end

      tdclc_pkg::ST_SCAN: begin
        if (pend_q && (rd_data == pix_q)) begin
          hit_d   = 1'b1;
          pend_d  = 1'b0;
          state_d = tdclc_pkg::ST_DONE;
        end else if (pend_q && pend_last_q) begin
          pend_d  = 1'b0;
          state_d = tdclc_pkg::ST_DONE;
        end else if (idx_q < total_q) begin
          // issue next read; compare lands in the following cycle
          rd_en       = 1'b1;
          pend_d      = 1'b1;
          pend_last_d = ((idx_q + CNT_W'(1)) == total_q);
          idx_d       = idx_q + CNT_W'(1);
        end
      end

      tdclc_pkg::ST_DONE: begin
        if (slot_free) begin
          wr_en        = ins;
          out_valid_d  = 1'b1;
          out_ovf_d    = ovf;
          out_failed_d = fail_new;
          out_last_d   = last_q;
          if (32'(tot_new) > tdclc_pkg::COUNT_SAT) begin
            out_cnt_d = tdclc_pkg::OUT_CNT_W'(tdclc_pkg::COUNT_SAT);
          end else begin
            out_cnt_d = tdclc_pkg::OUT_CNT_W'(tot_new);
          end
          // last pixel of the tile resets the count and failed flag after its result
          total_d  = last_q ? '0 : tot_new;
          failed_d = last_q ? 1'b0 : fail_new;
          state_d  = tdclc_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = tdclc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tdclc_pkg::ST_IDLE;
      transp_q    <= tdclc_pkg::TRANSP_RESET;
      total_q     <= '0;
      failed_q    <= 1'b0;
      idx_q       <= '0;
      pend_q      <= 1'b0;
      pend_last_q <= 1'b0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      total_q     <= total_d;
      failed_q    <= failed_d;
      idx_q       <= idx_d;
      pend_q      <= pend_d;
      pend_last_q <= pend_last_d;
      hit_q       <= hit_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        transp_q <= cfg_wdata_i;
      end
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk_i) begin
    cand_q       <= cand_d;
    pix_q        <= pix_d;
    last_q       <= last_d;
    out_ovf_q    <= out_ovf_d;
    out_cnt_q    <= out_cnt_d;
    out_failed_q <= out_failed_d;
    out_last_q   <= out_last_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_failed_q, out_cnt_q, out_ovf_q};
  assign m_axis_tlast  = out_last_q;

  // Checks
  `TDCLC_ASSERT_NOW(a_failed_full, clk_i, rst_ni, failed_q, total_q == CNT_W'(PALETTE_SIZE), "failed tile must hold full count")
  `TDCLC_ASSERT_NOW(a_live_in_store, clk_i, rst_ni, !failed_q, total_q <= CNT_W'(STORE_DEPTH), "live tile count exceeds store depth")
  `TDCLC_ASSERT_NOW(a_scan_bound, clk_i, rst_ni, state_q == tdclc_pkg::ST_SCAN, idx_q <= total_q, "scan index ran past stored colors")
  `TDCLC_ASSERT_NEXT(a_ovf_fails, clk_i, rst_ni, (state_q == tdclc_pkg::ST_DONE) && slot_free && ovf, out_valid_q && out_failed_q && failed_q == !out_last_q, "overflow must mark tile failed")

endmodule

[rtl/tdclc_store.sv]
// Color store: one write port, one read port with registered read data.
module tdclc_store #(
  parameter int unsigned DEPTH = tdclc_pkg::PALETTE_SIZE_DEF - 1,
  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                          clk_i,
  input  logic                          wr_en_i,
  input  logic [IDX_W-1:0]              wr_addr_i,
  input  logic [tdclc_pkg::COLOR_W-1:0] wr_data_i,
  input  logic                          rd_en_i,
  input  logic [IDX_W-1:0]              rd_addr_i,
  output logic [tdclc_pkg::COLOR_W-1:0] rd_data_o
);

  logic [tdclc_pkg::COLOR_W-1:0] mem_q [DEPTH];
  logic [tdclc_pkg::COLOR_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule
